@@ src/dtlv_pkg.sv @@
// ----------------------------------------------------------------------------
// dtlv_pkg
// shared types, attribute codes and decode helpers of the discovery tlv parser
// ----------------------------------------------------------------------------
package dtlv_pkg;

  localparam int MIN_PACKET   = 18;
  localparam int HEADER_BYTES = 4;

  // result queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int Q_CW    = 3;

  // dense attribute codes
  localparam logic [3:0] AC_MAC       = 4'd0;
  localparam logic [3:0] AC_IDENTITY  = 4'd1;
  localparam logic [3:0] AC_VERSION   = 4'd2;
  localparam logic [3:0] AC_PLATFORM  = 4'd3;
  localparam logic [3:0] AC_UPTIME    = 4'd4;
  localparam logic [3:0] AC_SOFTWARE  = 4'd5;
  localparam logic [3:0] AC_HARDWARE  = 4'd6;
  localparam logic [3:0] AC_IPV6      = 4'd7;
  localparam logic [3:0] AC_INTERFACE = 4'd8;
  localparam logic [3:0] AC_NONE      = 4'd15;

  // wire types of the attributes
  localparam logic [15:0] AT_MAC       = 16'h0001;
  localparam logic [15:0] AT_IDENTITY  = 16'h0005;
  localparam logic [15:0] AT_VERSION   = 16'h0007;
  localparam logic [15:0] AT_PLATFORM  = 16'h0008;
  localparam logic [15:0] AT_UPTIME    = 16'h000a;
  localparam logic [15:0] AT_SOFTWARE  = 16'h000b;
  localparam logic [15:0] AT_HARDWARE  = 16'h000c;
  localparam logic [15:0] AT_IPV6      = 16'h000f;
  localparam logic [15:0] AT_INTERFACE = 16'h0010;

  localparam logic [15:0] LEN_MAC    = 16'd6;
  localparam logic [15:0] LEN_UPTIME = 16'd4;
  localparam logic [15:0] LEN_IPV6   = 16'd16;

  // packet status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // result kinds
  localparam logic RK_VALUE   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  // out tdata layout, first member in the highest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic        uptime_valid;
    logic [31:0] uptime_seconds;
    logic        mac_valid;
    logic [47:0] mac_addr;
    logic        bad_fixed_length;
    logic [1:0]  status;
    logic        value_end;
    logic [10:0] value_index;
    logic [7:0]  value_byte;
    logic [3:0]  attr_code;
  } out_data_t;

  typedef struct packed {
    logic      kind;
    logic      last;
    out_data_t data;
  } result_t;

  function automatic logic [3:0] code_of(input logic [15:0] t);
    logic [3:0] c;
    case (t)
      AT_MAC:       c = AC_MAC;
      AT_IDENTITY:  c = AC_IDENTITY;
      AT_VERSION:   c = AC_VERSION;
      AT_PLATFORM:  c = AC_PLATFORM;
      AT_UPTIME:    c = AC_UPTIME;
      AT_SOFTWARE:  c = AC_SOFTWARE;
      AT_HARDWARE:  c = AC_HARDWARE;
      AT_IPV6:      c = AC_IPV6;
      AT_INTERFACE: c = AC_INTERFACE;
      default:      c = AC_NONE;
    endcase
    return c;
  endfunction

  // known attribute whose length fits its fixed size, if it has one
  function automatic logic attr_ok(input logic [3:0] code, input logic [15:0] len);
    logic ok;
    case (code)
      AC_NONE:   ok = 1'b0;
      AC_MAC:    ok = (len == LEN_MAC);
      AC_UPTIME: ok = (len == LEN_UPTIME);
      AC_IPV6:   ok = (len == LEN_IPV6);
      default:   ok = 1'b1;
    endcase
    return ok;
  endfunction

endpackage

@@ src/discovery_tlv_parser.sv @@
// ----------------------------------------------------------------------------
// discovery_tlv_parser
// parses type/length/value attributes of a discovery datagram, byte by byte
// ----------------------------------------------------------------------------
// One packet byte is taken per transfer and parsed in the same cycle into a
// four-entry result queue, so the block takes a byte every clock while the
// output keeps up. A byte causes at most two results (a value byte and, on the
// packet's last byte, the summary); the queue drains one result per clock
// while out_tready is high, and input stalls only while the queue holds more
// than two results.
// ----------------------------------------------------------------------------
module discovery_tlv_parser import dtlv_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // packet_length, data_byte, zero pad
  input  logic [0:0]   in_tuser,   // first_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // attr_code, value_byte, value_index, value_end,
                                   // status, bad_fixed_length, mac_addr,
                                   // mac_valid, uptime_seconds, uptime_valid, pad
  output logic [0:0]   out_tuser,  // result_kind
  output logic         out_tlast   // last
);

  localparam int LEN_CAP = (MAX_PACKET_BYTES < 2047) ? MAX_PACKET_BYTES : 2047;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_HEAD   = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;
  localparam logic [1:0] PH_TAIL   = 2'd3;

  logic [LEN_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] held_r, held_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [15:0]      clen_r, clen_nxt;
  logic [LEN_W-1:0] vc_r, vc_nxt;
  logic [47:0]      mac_r, mac_nxt;
  logic [31:0]      up_r, up_nxt;
  logic [2:0]       flags_r, flags_nxt;
  logic [1:0]       status_r, status_nxt;

  logic             in_fire;
  logic             first;
  logic [10:0]      len_in;
  logic [10:0]      len_nz;
  logic [LEN_W-1:0] len_sat;
  logic [7:0]       b;
  logic [LEN_W-1:0] p;
  logic [3:0]       code;
  logic             vend;
  logic             q_room;
  logic             q_valid;
  result_t          q_head;
  result_t          res0, res1, val_res, sum_res;
  logic [1:0]       n_res;
  logic             have_val;

  assign in_fire = in_tvalid && in_tready;
  assign first   = in_tuser[0];
  assign len_in  = in_tdata[10:0];
  assign b       = in_tdata[18:11];
  assign len_nz  = (len_in == 11'd0) ? 11'd1 : len_in;
  assign len_sat = (len_nz > 11'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_nz[LEN_W-1:0];

  always_comb begin
    pos_nxt    = pos_r;
    held_nxt   = held_r;
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    clen_nxt   = clen_r;
    vc_nxt     = vc_r;
    mac_nxt    = mac_r;
    up_nxt     = up_r;
    flags_nxt  = flags_r;
    status_nxt = status_r;
    p          = pos_r;
    code       = AC_NONE;
    vend       = 1'b0;
    have_val   = 1'b0;
    val_res    = '0;
    sum_res    = '0;
    res0       = '0;
    res1       = '0;
    n_res      = 2'd0;

    if (in_fire && (first || (pos_r < held_r))) begin
      if (first) begin
        held_nxt   = len_sat;
        p          = '0;
        phase_nxt  = PH_HEADER;
        type_nxt   = '0;
        clen_nxt   = '0;
        vc_nxt     = '0;
        mac_nxt    = '0;
        up_nxt     = '0;
        flags_nxt  = '0;
        status_nxt = (len_sat < LEN_W'(MIN_PACKET)) ? ST_SHORT : ST_OK;
      end

      if (status_nxt == ST_OK) begin
        case (phase_nxt)
          PH_HEADER: begin
            if ((LEN_W + 1)'(p) + (LEN_W + 1)'(1) >= (LEN_W + 1)'(HEADER_BYTES)) begin
              phase_nxt = PH_HEAD;
              vc_nxt    = '0;
            end
          end
          PH_HEAD: begin
            if (vc_nxt == '0 &&
                (LEN_W + 1)'(p) + (LEN_W + 1)'(4) >= (LEN_W + 1)'(held_nxt)) begin
              phase_nxt = PH_TAIL;
            end else begin
              if (vc_nxt < LEN_W'(2)) begin
                type_nxt = {type_nxt[7:0], b};
              end else begin
                clen_nxt = {clen_nxt[7:0], b};
              end
              if (vc_nxt == LEN_W'(3)) begin
                vc_nxt = '0;
                if (17'(p) + 17'd1 + 17'(clen_nxt) > 17'(held_nxt)) begin
                  status_nxt = ST_OVERFLOW;
                  phase_nxt  = PH_TAIL;
                end else begin
                  code = code_of(type_nxt);
                  if (code != AC_NONE && !attr_ok(code, clen_nxt)) begin
                    flags_nxt[2] = 1'b1;
                  end
                  if (clen_nxt != 16'd0) begin
                    phase_nxt = PH_VALUE;
                  end
                end
              end else begin
                vc_nxt = vc_nxt + LEN_W'(1);
              end
            end
          end
          PH_VALUE: begin
            code = code_of(type_nxt);
            vend = (17'(vc_nxt) + 17'd1 == 17'(clen_nxt));
            if (attr_ok(code, clen_nxt)) begin
              have_val                   = 1'b1;
              val_res.kind               = RK_VALUE;
              val_res.data.attr_code     = code;
              val_res.data.value_byte    = b;
              val_res.data.value_index   = 11'(vc_nxt);
              val_res.data.value_end     = vend;
              if (code == AC_MAC) begin
                mac_nxt = {mac_nxt[39:0], b};
                if (vend) begin
                  flags_nxt[0] = 1'b1;
                end
              end else if (code == AC_UPTIME) begin
                up_nxt = {b, up_nxt[31:8]};
                if (vend) begin
                  flags_nxt[1] = 1'b1;
                end
              end
            end
            if (17'(vc_nxt) + 17'd1 >= 17'(clen_nxt)) begin
              vc_nxt    = '0;
              phase_nxt = PH_HEAD;
            end else begin
              vc_nxt = vc_nxt + LEN_W'(1);
            end
          end
          default: begin
          end
        endcase
      end

      pos_nxt = p + LEN_W'(1);

      sum_res.kind                  = RK_SUMMARY;
      sum_res.data.status           = status_nxt;
      sum_res.data.bad_fixed_length = flags_nxt[2];
      sum_res.data.mac_addr         = flags_nxt[0] ? mac_nxt : 48'd0;
      sum_res.data.mac_valid        = flags_nxt[0];
      sum_res.data.uptime_seconds   = flags_nxt[1] ? up_nxt : 32'd0;
      sum_res.data.uptime_valid     = flags_nxt[1];

      if (have_val) begin
        res0  = val_res;
        n_res = 2'd1;
      end
      if (pos_nxt == held_nxt) begin
        sum_res.last = 1'b1;
        if (have_val) begin
          res1  = sum_res;
          n_res = 2'd2;
        end else begin
          res0  = sum_res;
          n_res = 2'd1;
        end
      end else begin
        res0.last = have_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      held_r   <= '0;
      phase_r  <= PH_HEADER;
      type_r   <= '0;
      clen_r   <= '0;
      vc_r     <= '0;
      mac_r    <= '0;
      up_r     <= '0;
      flags_r  <= '0;
      status_r <= ST_OK;
    end else begin
      pos_r    <= pos_nxt;
      held_r   <= held_nxt;
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      clen_r   <= clen_nxt;
      vc_r     <= vc_nxt;
      mac_r    <= mac_nxt;
      up_r     <= up_nxt;
      flags_r  <= flags_nxt;
      status_r <= status_nxt;
    end
  end

  dtlv_rq u_rq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (n_res),
    .push_d0    (res0),
    .push_d1    (res1),
    .room       (q_room),
    .pop        (out_tready),
    .head_valid (q_valid),
    .head_d     (q_head)
  );

  assign in_tready  = q_room;
  assign out_tvalid = q_valid;
  assign out_tdata  = q_head.data;
  assign out_tuser  = q_head.kind;
  assign out_tlast  = q_head.last;

  assert property (@(posedge clk) disable iff (!rst_n) pos_r <= held_r)
    else $error("byte position past packet length");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("summary transfer without last");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_tvalid && !out_tuser[0] |-> out_tdata[25:24] == ST_OK)
    else $error("value transfer carries a status");

endmodule

@@ src/dtlv_rq.sv @@
// ----------------------------------------------------------------------------
// dtlv_rq
// result queue: takes up to two results a cycle, hands out one per transfer
// ----------------------------------------------------------------------------
module dtlv_rq import dtlv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push_d0,
  input  result_t    push_d1,
  output logic       room,
  input  logic       pop,
  output logic       head_valid,
  output result_t    head_d
);

  result_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, wp_nxt;
  logic [Q_AW-1:0]   rp_r, rp_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic [Q_AW-1:0]   wp_1;

  assign room       = (cnt_r <= Q_CW'(Q_DEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head_d     = mem_r[rp_r];
  assign wp_1       = wp_r + Q_AW'(1);

  always_comb begin
    wp_nxt  = wp_r + Q_AW'(push_cnt);
    rp_nxt  = (pop && head_valid) ? rp_r + Q_AW'(1) : rp_r;
    cnt_nxt = cnt_r + Q_CW'(push_cnt) - Q_CW'(pop && head_valid);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wp_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wp_1] <= push_d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= Q_CW'(Q_DEPTH))
    else $error("result queue count above depth");
  assert property (@(posedge clk) disable iff (!rst_n) (push_cnt != 2'd0) |-> room)
    else $error("result pushed without room");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (cnt_r > Q_CW'(Q_DEPTH - 2)) |-> !room)
    else $error("room reported with fewer than two free entries");

endmodule

@@ tb/discovery_tlv_parser_tb.sv @@
// ----------------------------------------------------------------------------
// discovery_tlv_parser_tb
// Drives discovery datagrams into the attribute parser one byte per transfer.
// The stimulus covers well-formed packets, fixed-length attributes with wrong
// lengths, overflowing attributes, short packets, noise, stray bytes and
// packets cut off by a new first byte. A built-in parser works out every
// value and summary result, and each output transfer is checked field by field.
// ----------------------------------------------------------------------------
module discovery_tlv_parser_tb import dtlv_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_PKT = 2048;
  localparam logic [15:0] PAD_TYPE = 16'h00ff;

  typedef enum logic [1:0] {PH_HEADER, PH_ATTR_HEAD, PH_VALUE, PH_TAIL} parse_phase_e;
  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;   // packet_length, data_byte, zero pad
  logic [0:0] in_tuser = '0;    // first_byte
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;      // attr_code, value_byte, value_index, value_end,
                                // status, bad_fixed_length, mac_addr,
                                // mac_valid, uptime_seconds, uptime_valid, pad
  logic [0:0] out_tuser;        // result_kind
  logic out_tlast;

  // parser state mirrored on the accepted bytes
  int unsigned rx_pos = 0;
  int unsigned rx_len = 0;
  parse_phase_e rx_phase = PH_HEADER;
  logic [15:0] tlv_type = '0;
  logic [15:0] attr_len = '0;
  int unsigned attr_count = 0;
  logic [47:0] mac_acc = '0;
  logic [31:0] uptime_acc = '0;
  logic mac_seen = 1'b0;
  logic uptime_seen = 1'b0;
  logic bad_len_seen = 1'b0;
  logic [1:0] rx_status = ST_OK;

  result_t expected_results[$];
  int mismatches = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int send_idle = 0;
  int recv_stall = 0;

  discovery_tlv_parser uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("discovery_tlv_parser_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [3:0] dense_code(input logic [15:0] t);
    case (t)
      AT_MAC:       return AC_MAC;
      AT_IDENTITY:  return AC_IDENTITY;
      AT_VERSION:   return AC_VERSION;
      AT_PLATFORM:  return AC_PLATFORM;
      AT_UPTIME:    return AC_UPTIME;
      AT_SOFTWARE:  return AC_SOFTWARE;
      AT_HARDWARE:  return AC_HARDWARE;
      AT_IPV6:      return AC_IPV6;
      AT_INTERFACE: return AC_INTERFACE;
      default:      return AC_NONE;
    endcase
  endfunction

  // value bytes are emitted only for known types at their required length
  function automatic logic emits_values(input logic [3:0] code, input logic [15:0] len);
    logic [15:0] need;
    need = '0;
    if (code == AC_NONE) return 1'b0;
    if (code == AC_MAC) need = LEN_MAC;
    if (code == AC_UPTIME) need = LEN_UPTIME;
    if (code == AC_IPV6) need = LEN_IPV6;
    return (need == '0) || (need == len);
  endfunction

  function automatic result_t value_result(input logic [3:0] code, input logic [7:0] b,
                                           input logic [10:0] idx, input logic vend);
    result_t r;
    r = '0;
    r.kind = RK_VALUE;
    r.data.attr_code = code;
    r.data.value_byte = b;
    r.data.value_index = idx;
    r.data.value_end = vend;
    return r;
  endfunction

  function automatic result_t summary_result();
    result_t r;
    r = '0;
    r.kind = RK_SUMMARY;
    r.data.status = rx_status;
    r.data.bad_fixed_length = bad_len_seen;
    r.data.mac_valid = mac_seen;
    r.data.mac_addr = mac_seen ? mac_acc : '0;
    r.data.uptime_valid = uptime_seen;
    r.data.uptime_seconds = uptime_seen ? uptime_acc : '0;
    return r;
  endfunction

  task automatic parse_into_expected(input logic fb, input logic [10:0] len,
                                     input logic [7:0] b);
    int unsigned hl;
    int unsigned p;
    logic [3:0] code;
    logic vend;
    result_t batch[$];
    if (fb) begin
      hl = (len == 0) ? 1 : len;
      if (hl > MAX_PKT) hl = MAX_PKT;
      rx_len = hl;
      rx_pos = 0;
      rx_phase = PH_HEADER;
      tlv_type = '0;
      attr_len = '0;
      attr_count = 0;
      mac_acc = '0;
      uptime_acc = '0;
      mac_seen = 1'b0;
      uptime_seen = 1'b0;
      bad_len_seen = 1'b0;
      rx_status = (hl < MIN_PACKET) ? ST_SHORT : ST_OK;
    end else if (rx_pos >= rx_len) begin
      return;
    end
    p = rx_pos;
    if (rx_status == ST_OK) begin
      case (rx_phase)
        PH_HEADER: begin
          if (p + 1 >= HEADER_BYTES) begin
            rx_phase = PH_ATTR_HEAD;
            attr_count = 0;
          end
        end
        PH_ATTR_HEAD: begin
          if (attr_count == 0 && p + 4 >= rx_len) begin
            rx_phase = PH_TAIL;
          end else begin
            if (attr_count < 2) tlv_type = {tlv_type[7:0], b};
            else attr_len = {attr_len[7:0], b};
            attr_count++;
            if (attr_count >= 4) begin
              attr_count = 0;
              if (p + 1 + attr_len > rx_len) begin
                rx_status = ST_OVERFLOW;
                rx_phase = PH_TAIL;
              end else begin
                code = dense_code(tlv_type);
                if (code != AC_NONE && !emits_values(code, attr_len)) bad_len_seen = 1'b1;
                if (attr_len != 0) rx_phase = PH_VALUE;
              end
            end
          end
        end
        PH_VALUE: begin
          code = dense_code(tlv_type);
          if (emits_values(code, attr_len)) begin
            vend = (attr_count + 1 == attr_len);
            batch.push_back(value_result(code, b, 11'(attr_count), vend));
            if (code == AC_MAC) begin
              mac_acc = {mac_acc[39:0], b};
              if (vend) mac_seen = 1'b1;
            end else if (code == AC_UPTIME) begin
              uptime_acc = {b, uptime_acc[31:8]};
              if (vend) uptime_seen = 1'b1;
            end
          end
          attr_count++;
          if (attr_count >= attr_len) begin
            attr_count = 0;
            rx_phase = PH_ATTR_HEAD;
          end
        end
        default: ;
      endcase
    end
    rx_pos = p + 1;
    if (rx_pos == rx_len) batch.push_back(summary_result());
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", got.kind));
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", got.kind, want.kind);
    compare_field("last", got.last, want.last);
    compare_field("attr_code", got.data.attr_code, want.data.attr_code);
    compare_field("value_byte", got.data.value_byte, want.data.value_byte);
    compare_field("value_index", got.data.value_index, want.data.value_index);
    compare_field("value_end", got.data.value_end, want.data.value_end);
    compare_field("status", got.data.status, want.data.status);
    compare_field("bad_fixed_length", got.data.bad_fixed_length, want.data.bad_fixed_length);
    compare_field("mac_addr", got.data.mac_addr, want.data.mac_addr);
    compare_field("mac_valid", got.data.mac_valid, want.data.mac_valid);
    compare_field("uptime_seconds", got.data.uptime_seconds, want.data.uptime_seconds);
    compare_field("uptime_valid", got.data.uptime_valid, want.data.uptime_valid);
  endtask

  // result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      check_result(result_t'({out_tuser, out_tlast, out_tdata}));
    end
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_byte(input logic fb, input logic [10:0] len, input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, b, len};
    in_tuser <= fb;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_into_expected(fb, len, b);
  endtask

  // later bytes sometimes carry a different length, which must be ignored
  task automatic send_packet(input byte_q_t pk, input int unsigned len, input int unsigned count);
    logic [10:0] lf;
    for (int unsigned i = 0; i < count; i++) begin
      lf = (i == 0 || $urandom_range(7) != 0) ? 11'(len) : 11'($urandom);
      send_byte(i == 0, lf, pk[i]);
      bytes_sent++;
    end
  endtask

  function automatic logic [15:0] known_type(input int unsigned i);
    case (i)
      0:       return AT_MAC;
      1:       return AT_IDENTITY;
      2:       return AT_VERSION;
      3:       return AT_PLATFORM;
      4:       return AT_UPTIME;
      5:       return AT_SOFTWARE;
      6:       return AT_HARDWARE;
      7:       return AT_IPV6;
      default: return AT_INTERFACE;
    endcase
  endfunction

  function automatic void add_attr(ref byte_q_t pk, input logic [15:0] t,
                                   input logic [15:0] l, input int unsigned n);
    pk.push_back(t[15:8]);
    pk.push_back(t[7:0]);
    pk.push_back(l[15:8]);
    pk.push_back(l[7:0]);
    repeat (n) pk.push_back(8'($urandom));
  endfunction

  function automatic void build_attrs(ref byte_q_t pk, input int max_attrs, input bit with_tail);
    int unsigned sel;
    int tail;
    int fill;
    logic [15:0] t;
    logic [15:0] l;
    repeat (HEADER_BYTES) pk.push_back(8'($urandom));
    repeat ($urandom_range(max_attrs, 1)) begin
      sel = $urandom_range(15);
      t = known_type($urandom_range(8));
      if (sel < 10) begin
        case (t)
          AT_MAC:    l = LEN_MAC;
          AT_UPTIME: l = LEN_UPTIME;
          AT_IPV6:   l = LEN_IPV6;
          default:   l = 16'($urandom_range(12, 1));
        endcase
      end else if (sel < 12) begin
        t = known_type($urandom_range(2) == 0 ? 0 : ($urandom_range(1) ? 4 : 7));
        l = 16'($urandom_range(20));
      end else if (sel < 14) begin
        t = 16'($urandom);
        l = 16'($urandom_range(10));
      end else begin
        l = '0;
      end
      add_attr(pk, t, l, l);
    end
    tail = with_tail ? $urandom_range(4) : 0;
    if (int'(pk.size()) + tail < MIN_PACKET) begin
      fill = MIN_PACKET - int'(pk.size()) - tail - 4;
      if (fill < 0) fill = 0;
      add_attr(pk, PAD_TYPE, 16'(fill), fill);
    end
    repeat (tail) pk.push_back(8'($urandom));
  endfunction

  task automatic test_short_and_stray();
    byte_q_t pk;
    pk = '{8'hff};
    send_packet(pk, 0, 1);
    send_byte(1'b0, 11'h7ff, 8'hff);
    send_byte(1'b0, 11'h000, 8'h00);
  endtask

  // mac and uptime, then an unknown zero-length attribute ending on the last byte
  task automatic test_attributes();
    byte_q_t pk;
    pk = '{8'hff, 8'h00, 8'hff, 8'h00};
    add_attr(pk, AT_MAC, LEN_MAC, 0);
    pk = {pk, 8'hff, 8'h00, 8'h12, 8'h34, 8'h56, 8'hab};
    add_attr(pk, AT_UPTIME, LEN_UPTIME, 0);
    pk = {pk, 8'h78, 8'h56, 8'h34, 8'hff};
    add_attr(pk, 16'hffff, 16'h0000, 0);
    send_packet(pk, pk.size(), pk.size());
  endtask

  task automatic test_restart_overflow();
    byte_q_t pk;
    pk = '{8'h00, 8'hff, 8'h00};
    send_packet(pk, 2047, 3);
    pk.delete();
    repeat (HEADER_BYTES) pk.push_back(8'($urandom));
    add_attr(pk, AT_IPV6, 16'hffff, 10);
    send_packet(pk, pk.size(), pk.size());
  endtask

  task automatic test_random_traffic(input int target);
    byte_q_t pk;
    int stop;
    int unsigned sel;
    int unsigned n;
    logic [15:0] l;
    stop = bytes_sent + target;
    while (bytes_sent < stop) begin
      sel = $urandom_range(99);
      pk.delete();
      if (sel < 55) begin
        build_attrs(pk, 6, 1'b1);
        send_packet(pk, pk.size(), pk.size());
      end else if (sel < 68) begin
        build_attrs(pk, 2, 1'b0);
        l = $urandom_range(1) ? 16'($urandom_range(30, 2))
                              : {8'($urandom_range(255, 1)), 8'($urandom)};
        add_attr(pk, $urandom_range(3) == 0 ? 16'($urandom) : known_type($urandom_range(8)),
                 l, 0);
        repeat ($urandom_range(l > 21 ? 20 : l - 1, 1)) pk.push_back(8'($urandom));
        send_packet(pk, pk.size(), pk.size());
      end else if (sel < 78) begin
        n = $urandom_range(17);
        repeat (n == 0 ? 1 : n) pk.push_back(8'($urandom));
        send_packet(pk, n, pk.size());
      end else if (sel < 86) begin
        repeat ($urandom_range(60, MIN_PACKET)) pk.push_back(8'($urandom));
        send_packet(pk, pk.size(), pk.size());
      end else if (sel < 94) begin
        build_attrs(pk, 6, 1'b1);
        n = ($urandom_range(3) == 0) ? $urandom_range(2047, 1024) : pk.size();
        send_packet(pk, n, $urandom_range(pk.size() - 1, 1));
      end else begin
        repeat ($urandom_range(3, 1)) send_byte(1'b0, 11'($urandom), 8'($urandom));
        build_attrs(pk, 4, 1'b1);
        send_packet(pk, pk.size(), pk.size());
      end
    end
  endtask

  // one long packet so the length field and the value index reach bit 10
  task automatic test_long_packet();
    byte_q_t pk;
    repeat (HEADER_BYTES) pk.push_back(8'($urandom));
    add_attr(pk, AT_IDENTITY, 16'd1030, 1030);
    add_attr(pk, AT_MAC, LEN_MAC, 6);
    pk.push_back(8'($urandom));
    send_packet(pk, pk.size(), pk.size());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_short_and_stray();
    test_attributes();
    test_restart_overflow();
    send_idle = 0;
    recv_stall = 0;
    test_random_traffic(70);
    send_idle = 74;
    recv_stall = 0;
    test_random_traffic(70);
    send_idle = 0;
    recv_stall = 74;
    test_random_traffic(70);
    send_idle = 13;
    recv_stall = 13;
    test_random_traffic(70);
    send_idle = 0;
    recv_stall = 0;
    test_long_packet();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("discovery_tlv_parser_tb: PASS");
    end else begin
      $display("discovery_tlv_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dtlv_pkg.sv
src/dtlv_rq.sv
src/discovery_tlv_parser.sv
tb/discovery_tlv_parser_tb.sv
